// ===== rtl/dlbd_pkg.sv =====
`default_nettype none

package dlbd_pkg;

  localparam int LEN_W          = 30;
  localparam int BYTE_W         = 8;
  localparam int STATUS_W       = 2;
  localparam int MAX_DIGITS_DEF = 9;

  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = LEN_W'(65536);
  localparam logic [BYTE_W-1:0] HASH_BYTE      = 8'h23;
  localparam logic [BYTE_W-1:0] ASCII_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] DEC_MAX_DIGIT  = 8'd9;

  typedef enum logic [STATUS_W-1:0] {
    ST_DATA     = 2'd0,
    ST_HDR_ERR  = 2'd1,
    ST_SIZE_ERR = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              is_last;
    status_t           status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dlbd_parser.sv =====
`default_nettype none

module dlbd_parser #(
  parameter int MAX_DIGITS = dlbd_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire logic [dlbd_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [dlbd_pkg::LEN_W-1:0]  max_length,
  output logic                            res_valid,
  output dlbd_pkg::result_t               res
);
  import dlbd_pkg::*;

  localparam int DW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    PH_HASH  = 2'd0,
    PH_COUNT = 2'd1,
    PH_LEN   = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [DW-1:0]     digits_left_r, digits_left_nxt;
  logic [LEN_W-1:0]  length_acc_r, length_acc_nxt;
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;

  logic [BYTE_W-1:0] digit;
  logic [LEN_W-1:0]  acc_step;
  logic [DW-1:0]     digits_dec;
  logic [LEN_W-1:0]  bytes_dec;

  // bytes below '0' wrap to large values and fail the digit checks
  assign digit      = rx_byte - ASCII_ZERO;
  assign acc_step   = (length_acc_r << 3) + (length_acc_r << 1) + LEN_W'(digit);
  assign digits_dec = digits_left_r - DW'(1);
  assign bytes_dec  = bytes_left_r - LEN_W'(1);

  always_comb begin
    phase_nxt        = phase_r;
    digits_left_nxt  = digits_left_r;
    length_acc_nxt   = length_acc_r;
    bytes_left_nxt   = bytes_left_r;
    res_valid        = 1'b0;
    res.payload_byte = '0;
    res.is_last      = 1'b1;
    res.status       = ST_HDR_ERR;
    case (phase_r)
      PH_HASH: begin
        if (rx_byte == HASH_BYTE) begin
          phase_nxt = PH_COUNT;
        end else begin
          res_valid = 1'b1;
        end
      end
      PH_COUNT: begin
        if (digit >= 8'd1 && digit <= BYTE_W'(MAX_DIGITS)) begin
          digits_left_nxt = DW'(digit);
          length_acc_nxt  = '0;
          phase_nxt       = PH_LEN;
        end else begin
          phase_nxt = PH_HASH;
          res_valid = 1'b1;
        end
      end
      PH_LEN: begin
        if (digit > DEC_MAX_DIGIT) begin
          phase_nxt       = PH_HASH;
          digits_left_nxt = '0;
          res_valid       = 1'b1;
        end else begin
          length_acc_nxt  = acc_step;
          digits_left_nxt = digits_dec;
          if (digits_dec == '0) begin
            if (acc_step > max_length) begin
              phase_nxt  = PH_HASH;
              res_valid  = 1'b1;
              res.status = ST_SIZE_ERR;
            end else if (acc_step == '0) begin
              phase_nxt  = PH_HASH;
              res_valid  = 1'b1;
              res.status = ST_EMPTY;
            end else begin
              bytes_left_nxt = acc_step;
              phase_nxt      = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        bytes_left_nxt   = bytes_dec;
        res_valid        = 1'b1;
        res.payload_byte = rx_byte;
        res.status       = ST_DATA;
        res.is_last      = (bytes_dec == '0);
        if (bytes_dec == '0) begin
          phase_nxt = PH_HASH;
        end
      end
      default: begin
        phase_nxt = PH_HASH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HASH;
      digits_left_r <= '0;
      length_acc_r  <= '0;
      bytes_left_r  <= '0;
    end else if (go) begin
      phase_r       <= phase_nxt;
      digits_left_r <= digits_left_nxt;
      length_acc_r  <= length_acc_nxt;
      bytes_left_r  <= bytes_left_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dlbd_out_reg.sv =====
`default_nettype none

module dlbd_out_reg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         load,
  input  wire logic                         load_valid,
  input  wire dlbd_pkg::result_t            load_res,
  output logic                              can_load,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [dlbd_pkg::BYTE_W-1:0]       out_tdata,  // payload_byte
  output logic                              out_tlast,  // is_last
  output logic [dlbd_pkg::STATUS_W-1:0]     out_tuser   // status
);
  import dlbd_pkg::*;

  logic    valid_r;
  result_t res_r;

  // slot is free when empty or being drained this cycle
  assign can_load = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load && load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res_r <= load_res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.payload_byte;
  assign out_tlast  = res_r.is_last;
  assign out_tuser  = res_r.status;

endmodule

`default_nettype wire

// ===== rtl/definite_length_block_deframer.sv =====
`default_nettype none

// Parses definite-length arbitrary blocks ('#', digit count, decimal length
// digits, payload) from a byte stream and passes the payload bytes out, the
// final one marked by out_tlast. Header bytes produce no output; a zero-length
// block gives one empty-block request, and a bad header or a length above
// cfg max_length gives one error request, after which the parser waits for '#'.
// out_tuser carries the status: 0 data, 1 header error, 2 size error, 3 empty.
// One byte is accepted per cycle unless out_tready holds the output; each
// byte is held in the input register, and its result, decoded by the parser
// combinationally, is held in the output register. cfg_wr_en writes
// max_length (reset 65536); write it only while the block is idle.

module definite_length_block_deframer #(
  parameter int MAX_DIGITS = dlbd_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [dlbd_pkg::BYTE_W-1:0]   in_tdata,    // rx_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [dlbd_pkg::BYTE_W-1:0]        out_tdata,   // payload_byte
  output logic                               out_tlast,   // is_last
  output logic [dlbd_pkg::STATUS_W-1:0]      out_tuser,   // status
  input  wire logic                          cfg_wr_en,
  input  wire logic [dlbd_pkg::LEN_W-1:0]    cfg_wr_data  // max_length
);
  import dlbd_pkg::*;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic [LEN_W-1:0]  max_length_r;
  logic              can_load;
  logic              advance;
  logic              res_valid;
  result_t           res;

  assign advance   = in_valid_r && can_load;
  assign in_tready = !in_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RST;
    end else if (cfg_wr_en) begin
      max_length_r <= cfg_wr_data;
    end
  end

  dlbd_parser #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (advance),
    .rx_byte    (in_byte_r),
    .max_length (max_length_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  dlbd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .load_valid (res_valid),
    .load_res   (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
